// ----- rtl/lap_edge_pkg.sv -----
package lap_edge_pkg;

  // Line store geometry.
  localparam int MAX_LINE_WIDTH = 2048;
  localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
  localparam int ROW_W          = 12;

  // Configuration register widths and limits.
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int DIM_MIN      = 3;
  localparam int HEIGHT_MAX   = 4096;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  // Queue between the window front end and the filter back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  // Kernel arithmetic.
  localparam int          PIX_W    = 8;
  localparam int          SUM_W    = 11;
  localparam logic [10:0] PIX_MAX  = 11'd255;
  localparam int          NUM_TAPS = 9;
  localparam int          CENTRE   = 4;

  // One RGB pixel, red in the lowest byte.
  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  // A complete 3x3 window with the coordinates of its centre.
  // Taps 0..2 are the oldest column, 6..8 the newest, each top to bottom.
  typedef struct packed {
    logic                      frame_done;
    logic [ROW_W-1:0]          y;
    logic [COL_W-1:0]          x;
    pixel_t [NUM_TAPS-1:0]     win;
  } win_item_t;

endpackage

// ----- rtl/lap_edge_ram.sv -----
module lap_edge_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/lap_edge_front.sv -----
module lap_edge_front import lap_edge_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  pixel_t                in_pix,
  output logic                  in_ready,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [QLVL_W-1:0]     q_level,
  output logic                  push,
  output win_item_t             push_item
);

  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [COL_W-1:0]        w_last;
  logic [ROW_W-1:0]        h_last;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             accept;
  logic             restart;
  logic             last_col;
  logic             last_row;

  logic             s1_valid_r;
  pixel_t           s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_interior_r;
  logic             s1_done_r;

  pixel_t [5:0]     win_r;
  pixel_t           up_rd;
  pixel_t           mid_rd;
  logic [23:0]      up_raw;
  logic [23:0]      mid_raw;
  logic [QLVL_W-1:0] in_flight;

  // Configuration registers; a write to either one restarts the frame.
  assign restart = cfg_valid &&
                   ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        width_r <= cfg_data[WIDTH_REG_W-1:0];
      end
      if (cfg_index == REG_IMAGE_HEIGHT) begin
        height_r <= cfg_data[HEIGHT_REG_W-1:0];
      end
    end
  end

  // Saturate the frame size to the supported range.
  always_comb begin
    if (width_r < WIDTH_REG_W'(DIM_MIN)) begin
      w_eff = WIDTH_REG_W'(DIM_MIN);
    end else if (int'(width_r) > MAX_LINE_WIDTH) begin
      w_eff = WIDTH_REG_W'(MAX_LINE_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r < HEIGHT_REG_W'(DIM_MIN)) begin
      h_eff = HEIGHT_REG_W'(DIM_MIN);
    end else if (int'(height_r) > HEIGHT_MAX) begin
      h_eff = HEIGHT_REG_W'(HEIGHT_MAX);
    end else begin
      h_eff = height_r;
    end
  end

  assign w_last = COL_W'(w_eff - WIDTH_REG_W'(1));
  assign h_last = ROW_W'(h_eff - HEIGHT_REG_W'(1));

  // Requests are taken only while the queue has room for every item in flight,
  // so the stage after the line store read never has to stall.
  assign in_flight = q_level + QLVL_W'(s1_valid_r);
  assign in_ready  = (in_flight < QLVL_W'(QUEUE_DEPTH));
  assign accept    = in_valid && in_ready;

  // Raster position of the incoming pixel.
  assign last_col = (col_r == w_last);
  assign last_row = (row_r == h_last);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage one holds the pixel while the line stores return its column.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r      <= in_pix;
      s1_col_r      <= col_r;
      s1_row_r      <= row_r;
      s1_interior_r <= (col_r >= COL_W'(2)) && (row_r >= ROW_W'(2));
      s1_done_r     <= last_col && last_row;
    end
  end

  // Two line stores; each column is read on accept and rewritten in the cycle after.
  lap_edge_ram #(.WIDTH(24), .DEPTH(MAX_LINE_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (mid_raw),
    .re    (accept),
    .raddr (col_r),
    .rdata (up_raw)
  );

  lap_edge_ram #(.WIDTH(24), .DEPTH(MAX_LINE_WIDTH)) u_middle (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .re    (accept),
    .raddr (col_r),
    .rdata (mid_raw)
  );

  assign up_rd  = pixel_t'(up_raw);
  assign mid_rd = pixel_t'(mid_raw);

  // The window keeps the two previous columns and shifts by one per pixel.
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      win_r <= '0;
    end else if (s1_valid_r) begin
      win_r <= {s1_pix_r, mid_rd, up_rd, win_r[5:3]};
    end
  end

  // Interior pixels complete a window centred one row and one column back.
  assign push                 = s1_valid_r && s1_interior_r;
  assign push_item.win        = {s1_pix_r, mid_rd, up_rd, win_r};
  assign push_item.x          = s1_col_r - COL_W'(1);
  assign push_item.y          = s1_row_r - ROW_W'(1);
  assign push_item.frame_done = s1_done_r;

endmodule

// ----- rtl/lap_edge_queue.sv -----
module lap_edge_queue import lap_edge_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  win_item_t         push_item,
  input  logic              pop,
  output logic              head_valid,
  output win_item_t         head_item,
  output logic [QLVL_W-1:0] level
);

  win_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QLVL_W-1:0] count_r;
  logic              do_pop;

  assign do_pop = pop && (count_r != '0);

  // The front end never pushes into a full queue, as it holds back requests.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QLVL_W'(push) - QLVL_W'(do_pop);
    end
  end

  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign level      = count_r;

endmodule

// ----- rtl/lap_edge_back.sv -----
module lap_edge_back import lap_edge_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  win_item_t        head_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [COL_W-1:0] out_x,
  output logic [ROW_W-1:0] out_y,
  output pixel_t           out_pix,
  output logic             out_done
);

  logic [NUM_TAPS-1:0][PIX_W-1:0] red_taps;
  logic [NUM_TAPS-1:0][PIX_W-1:0] green_taps;
  logic [NUM_TAPS-1:0][PIX_W-1:0] blue_taps;
  pixel_t                         result;

  logic             out_valid_r;
  logic [COL_W-1:0] out_x_r;
  logic [ROW_W-1:0] out_y_r;
  pixel_t           out_pix_r;
  logic             out_done_r;

  // Eight times the centre minus the eight neighbours, clamped to 0..255.
  function automatic logic [PIX_W-1:0] laplace(input logic [NUM_TAPS-1:0][PIX_W-1:0] v);
    logic [SUM_W-1:0] nsum;
    logic [SUM_W-1:0] ctr;
    logic [SUM_W-1:0] diff;
    logic [PIX_W-1:0] res;
    nsum = '0;
    for (int i = 0; i < NUM_TAPS; i++) begin
      if (i != CENTRE) begin
        nsum = nsum + SUM_W'(v[i]);
      end
    end
    ctr  = {v[CENTRE], 3'b000};
    diff = ctr - nsum;
    if (ctr <= nsum) begin
      res = '0;
    end else if (diff >= PIX_MAX) begin
      res = PIX_MAX[PIX_W-1:0];
    end else begin
      res = diff[PIX_W-1:0];
    end
    return res;
  endfunction

  // Split the window into its three colour planes.
  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      red_taps[i]   = head_item.win[i].red;
      green_taps[i] = head_item.win[i].green;
      blue_taps[i]  = head_item.win[i].blue;
    end
  end

  assign result.red   = laplace(red_taps);
  assign result.green = laplace(green_taps);
  assign result.blue  = laplace(blue_taps);

  // The output register takes a new result whenever it is empty or being drained.
  assign pop = head_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_x_r    <= head_item.x;
      out_y_r    <= head_item.y;
      out_pix_r  <= result;
      out_done_r <= head_item.frame_done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_pix   = out_pix_r;
  assign out_done  = out_done_r;

endmodule

// ----- rtl/laplacian_edge_detect_rgb.sv -----
// 3x3 Laplacian edge detector for a raster-order stream of 24-bit RGB pixels.
// Input stream: one pixel per request on in_tdata, red in the lowest byte.
// Output stream: one request per interior pixel with its column, row and the
// clamped response of each channel; tlast marks the last interior pixel of a frame.
// Configuration: cfg_index 0 writes the line width, 1 the frame height. Writes
// are always taken, restart the frame and must only come while the block is idle.
// Throughput is one pixel per clock while the output is not stalled. An accepted
// pixel reads the line stores, its window is then written into the queue, and the
// filtered result is loaded into the output register once that register is empty
// or being drained.
// Rows 0 and 1 and columns 0 and 1 of each frame give no result.
// When the receiver stalls, windows collect in the four-entry window queue;
// in_tready falls once the queue and the line store read stage could fill it.
// Reset (rst_n low, synchronous) restores a 640 x 480 frame, clears the window,
// the raster counters and the queue. The line stores are not cleared; every
// entry that feeds a result is written on the first rows of a frame.
module laplacian_edge_detect_rgb import lap_edge_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // x[10:0], y[22:11], red, green, blue, zero pad
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic              push;
  win_item_t         push_item;
  logic              pop;
  logic              head_valid;
  win_item_t         head_item;
  logic [QLVL_W-1:0] q_level;
  logic [COL_W-1:0]  res_x;
  logic [ROW_W-1:0]  res_y;
  pixel_t            res_pix;

  assign cfg_ready = 1'b1;

  // Front end: raster counters, line stores and the window.
  lap_edge_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_pix    (pixel_t'(in_tdata)),
    .in_ready  (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_level   (q_level),
    .push      (push),
    .push_item (push_item)
  );

  // Short queue of complete windows.
  lap_edge_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .level      (q_level)
  );

  // Back end: kernel, clamp and output register.
  lap_edge_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_x      (res_x),
    .out_y      (res_y),
    .out_pix    (res_pix),
    .out_done   (out_tlast)
  );

  assign out_tdata = {1'b0, res_pix.blue, res_pix.green, res_pix.red, res_y, res_x};

endmodule
